FILE: rtl/tbcd_pkg.sv
// Package for the two-beam crossing detector: types, codes and reset values.
package tbcd_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TRANSIT_MIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINGER_MAX      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_TIME = 2'd2;

    localparam logic [CFG_W-1:0] TRANSIT_MIN_RST     = 16'd50;
    localparam logic [CFG_W-1:0] LINGER_MAX_RST      = 16'd3000;
    localparam logic [CFG_W-1:0] REFRACTORY_TIME_RST = 16'd200;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE       = 2'd0,
        MODE_PEND_IN    = 2'd1,
        MODE_PEND_OUT   = 2'd2,
        MODE_REFRACTORY = 2'd3
    } tbcd_mode_t;

    typedef enum logic [1:0] {
        CROSS_NONE = 2'd0,
        CROSS_IN   = 2'd1,
        CROSS_OUT  = 2'd2
    } tbcd_crossing_t;

    typedef struct packed {
        logic              kind;
        logic              beam_is_a;
        logic              beam_broken;
        logic [TIME_W-1:0] time_ms;
    } tbcd_item_t;

    typedef struct packed {
        tbcd_crossing_t   crossing;
        logic [CFG_W-1:0] transit_ms;
    } tbcd_result_t;

    typedef struct packed {
        logic [CFG_W-1:0] transit_min;
        logic [CFG_W-1:0] linger_max;
        logic [CFG_W-1:0] refractory_time;
    } tbcd_cfg_t;

endpackage

FILE: rtl/tbcd_channels.sv
// Request channel interfaces: beam/tick events in, crossing results out.
interface tbcd_item_if;
    import tbcd_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic              beam_is_a;
    logic              beam_broken;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, kind, beam_is_a, beam_broken, time_ms, input ready);
    modport sink   (input valid, kind, beam_is_a, beam_broken, time_ms, output ready);
endinterface

interface tbcd_result_if;
    import tbcd_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       crossing;
    logic [CFG_W-1:0] transit_ms;

    modport source (output valid, crossing, transit_ms, input ready);
    modport sink   (input valid, crossing, transit_ms, output ready);
endinterface

FILE: rtl/two_beam_crossing_detector_top.sv
// Top level of the two-beam crossing detector.
//
//   channel     dir  handshake        payload
//   item_in     in   valid / ready    kind, beam_is_a, beam_broken, time_ms
//   result_out  out  valid / ready    crossing, transit_ms
//   cfg         in   cfg_we           cfg_index, cfg_data
//
// One event per cycle sustained while result_out is not stalled; every event gives exactly one result.
// The path runs through the input register, then the single-pass state update
// into the result register.
// Reset empties both stages and restores beam state and register defaults.
// item_in.ready drops only when both stages hold data and result_out is stalled.
module two_beam_crossing_detector_top (
    input  logic                           clk,
    input  logic                           rst_n,
    tbcd_item_if.sink                      item_in,
    tbcd_result_if.source                  result_out,
    input  logic                           cfg_we,
    input  logic [tbcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tbcd_pkg::CFG_W-1:0]     cfg_data
);
    import tbcd_pkg::*;

    tbcd_cfg_t    cfg;
    tbcd_item_t   item;
    tbcd_result_t result;
    logic         fire;
    logic         out_free;

    tbcd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tbcd_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_in  (item_in),
        .out_free (out_free),
        .item     (item),
        .fire     (fire)
    );

    tbcd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    tbcd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .result     (result),
        .result_out (result_out),
        .out_free   (out_free)
    );

endmodule

FILE: rtl/tbcd_cfg_regs.sv
// Configuration registers: transit minimum, linger limit, refractory time.
module tbcd_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tbcd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tbcd_pkg::CFG_W-1:0]           cfg_data,
    output tbcd_pkg::tbcd_cfg_t                  cfg
);
    import tbcd_pkg::*;

    tbcd_cfg_t cfg_reg;
    tbcd_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TRANSIT_MIN:     cfg_next.transit_min     = cfg_data;
                CFG_LINGER_MAX:      cfg_next.linger_max      = cfg_data;
                CFG_REFRACTORY_TIME: cfg_next.refractory_time = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.transit_min     <= TRANSIT_MIN_RST;
            cfg_reg.linger_max      <= LINGER_MAX_RST;
            cfg_reg.refractory_time <= REFRACTORY_TIME_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/tbcd_in_stage.sv
// Input register: holds one accepted event until the core takes it.
module tbcd_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    tbcd_item_if.sink            item_in,
    input  logic                 out_free,
    output tbcd_pkg::tbcd_item_t item,
    output logic                 fire
);
    import tbcd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic       accept;
    tbcd_item_t item_reg;

    assign fire          = valid_reg && out_free;
    assign item_in.ready = !valid_reg || fire;
    assign accept        = item_in.valid && item_in.ready;
    assign valid_next    = accept || (valid_reg && !fire);
    assign item          = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind        <= item_in.kind;
            item_reg.beam_is_a   <= item_in.beam_is_a;
            item_reg.beam_broken <= item_in.beam_broken;
            item_reg.time_ms     <= item_in.time_ms;
        end
    end

endmodule

FILE: rtl/tbcd_core.sv
// Crossing state machine: beam states, pending crossing timing, refractory hold-off.
module tbcd_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  tbcd_pkg::tbcd_item_t   item,
    input  tbcd_pkg::tbcd_cfg_t    cfg,
    output tbcd_pkg::tbcd_result_t result
);
    import tbcd_pkg::*;

    tbcd_mode_t        mode_reg, mode_next;
    logic              a_broken_reg, a_broken_next;
    logic              b_broken_reg, b_broken_next;
    logic              second_seen_reg, second_seen_next;
    logic [TIME_W-1:0] first_break_reg, first_break_next;
    logic [TIME_W-1:0] refr_end_reg, refr_end_next;
    logic [CFG_W-1:0]  last_transit_reg, last_transit_next;

    logic              is_tick;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] since_refr;
    logic              exit_refr;
    tbcd_mode_t        ev_mode;
    logic              pending;
    logic              a_after;
    logic              b_after;
    logic              second_after;
    logic              close_now;
    logic              abandon;
    logic              counted;
    logic              decide;
    logic              open_new;

    // shared decode of the current event
    always_comb
    begin
        is_tick    = (item.kind == KIND_TICK);
        elapsed    = item.time_ms - first_break_reg;
        since_refr = item.time_ms - refr_end_reg;
        // exit test uses beam states from before this event
        exit_refr  = (mode_reg == MODE_REFRACTORY) && !since_refr[TIME_W-1]
                     && !a_broken_reg && !b_broken_reg;
        ev_mode    = exit_refr ? MODE_IDLE : mode_reg;
        pending    = (ev_mode == MODE_PEND_IN) || (ev_mode == MODE_PEND_OUT);
        a_after    = (!is_tick && item.beam_is_a) ? item.beam_broken : a_broken_reg;
        b_after    = (!is_tick && !item.beam_is_a) ? item.beam_broken : b_broken_reg;
        second_after = second_seen_reg
                     || (!is_tick && pending && item.beam_broken
                         && (item.beam_is_a == (ev_mode == MODE_PEND_OUT)));
        close_now  = !is_tick && pending && !a_after && !b_after;
        abandon    = is_tick && pending && (elapsed > {16'd0, cfg.linger_max});
        counted    = close_now && second_after
                     && (elapsed >= {16'd0, cfg.transit_min})
                     && (elapsed <= {16'd0, cfg.linger_max});
        decide     = close_now || abandon;
        open_new   = !is_tick && (ev_mode == MODE_IDLE) && item.beam_broken;
    end

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        if (fire)
        begin
            if (decide)
            begin
                mode_next = MODE_REFRACTORY;
            end
            else if (open_new)
            begin
                mode_next = item.beam_is_a ? MODE_PEND_IN : MODE_PEND_OUT;
            end
            else
            begin
                mode_next = ev_mode;
            end
        end
    end

    // datapath and result
    always_comb
    begin
        a_broken_next     = a_broken_reg;
        b_broken_next     = b_broken_reg;
        second_seen_next  = second_seen_reg;
        first_break_next  = first_break_reg;
        refr_end_next     = refr_end_reg;
        last_transit_next = last_transit_reg;
        if (fire)
        begin
            a_broken_next = a_after;
            b_broken_next = b_after;
            if (decide)
            begin
                second_seen_next = 1'b0;
                first_break_next = '0;
                refr_end_next    = item.time_ms + {16'd0, cfg.refractory_time};
            end
            else if (open_new)
            begin
                second_seen_next = 1'b0;
                first_break_next = item.time_ms;
            end
            else
            begin
                second_seen_next = second_after;
            end
            if (counted)
            begin
                last_transit_next = elapsed[CFG_W-1:0];
            end
        end

        unique case (ev_mode)
            MODE_PEND_IN:  result.crossing = counted ? CROSS_IN : CROSS_NONE;
            MODE_PEND_OUT: result.crossing = counted ? CROSS_OUT : CROSS_NONE;
            default:       result.crossing = CROSS_NONE;
        endcase
        result.transit_ms = counted ? elapsed[CFG_W-1:0] : last_transit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            a_broken_reg     <= 1'b0;
            b_broken_reg     <= 1'b0;
            second_seen_reg  <= 1'b0;
            first_break_reg  <= '0;
            refr_end_reg     <= '0;
            last_transit_reg <= '0;
        end
        else
        begin
            mode_reg         <= mode_next;
            a_broken_reg     <= a_broken_next;
            b_broken_reg     <= b_broken_next;
            second_seen_reg  <= second_seen_next;
            first_break_reg  <= first_break_next;
            refr_end_reg     <= refr_end_next;
            last_transit_reg <= last_transit_next;
        end
    end

    // a counted crossing always lands in refractory
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (result.crossing != CROSS_NONE) |=> mode_reg == MODE_REFRACTORY)
        else $error("counted crossing did not enter refractory");

    // ticks never count
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.kind == KIND_TICK) |-> result.crossing == CROSS_NONE)
        else $error("tick produced a crossing");

    // state holds while no event is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(mode_reg) && $stable(last_transit_reg) && $stable(refr_end_reg))
        else $error("state changed without an event");

    // stored transit matches the one reported with the counted crossing
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && counted |=> last_transit_reg == $past(result.transit_ms))
        else $error("reported transit differs from stored transit");

endmodule

FILE: rtl/tbcd_out_stage.sv
// Result register: holds one result until the sink takes it.
module tbcd_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  tbcd_pkg::tbcd_result_t result,
    tbcd_result_if.source          result_out,
    output logic                   out_free
);
    import tbcd_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    tbcd_result_t result_reg;

    assign out_free              = !valid_reg || result_out.ready;
    assign valid_next            = fire || (valid_reg && !result_out.ready);
    assign result_out.valid      = valid_reg;
    assign result_out.crossing   = result_reg.crossing;
    assign result_out.transit_ms = result_reg.transit_ms;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

endmodule
